/* sv/interval_map_range_table_core_defines.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the interval map range table
// Concurrent assertion wrappers; NO_ASSERTIONS compiles them out.
// ----------------------------------------------------------------------------
`ifndef INTERVAL_MAP_RANGE_TABLE_CORE_DEFINES_SVH
`define INTERVAL_MAP_RANGE_TABLE_CORE_DEFINES_SVH

`ifndef NO_ASSERTIONS
// checked on every edge out of reset
`define IMRT_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
// checked on every edge, reset included
`define IMRT_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define IMRT_ASSERT(lbl, prop, msg)
`define IMRT_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

/* sv/imrt_pkg.sv */
// ----------------------------------------------------------------------------
// imrt_pkg
// Shared constants, codes and types of the interval map range table.
// ----------------------------------------------------------------------------
`default_nettype none

package imrt_pkg;

	localparam int TABLE_DEPTH_DEF = 16;
	localparam int KEY_WIDTH_DEF   = 32;
	localparam int VALUE_WIDTH_DEF = 32;

	localparam logic CMD_ASSIGN = 1'b0;
	localparam logic CMD_LOOKUP = 1'b1;

	typedef enum logic [1:0] {
		STAT_DONE  = 2'd0,
		STAT_EMPTY = 2'd1,
		STAT_FULL  = 2'd2
	} status_t;

	// result of the shared key comparator
	typedef struct packed {
		logic lt;
		logic eq;
	} cmp_res_t;

endpackage

`default_nettype wire

/* sv/interval_map_range_table_core.sv */
// ----------------------------------------------------------------------------
// interval_map_range_table_core
// Sorted breakpoint table with range assign and point lookup.
// Lookup: one scan over the N breakpoints held; one memory read per cycle.
// Assign: two scan passes, plus a read and then a write for each entry past
//   range_end that moves.
// Empty range: ends at the check, with no scan. One item at a time; a result register frees the input.
// Reset clears the entry count and default_value; memory contents stay unknown.
// ----------------------------------------------------------------------------
`default_nettype none

`include "interval_map_range_table_core_defines.svh"

module interval_map_range_table_core #(
	parameter int TABLE_DEPTH = imrt_pkg::TABLE_DEPTH_DEF,
	parameter int KEY_WIDTH   = imrt_pkg::KEY_WIDTH_DEF,
	parameter int VALUE_WIDTH = imrt_pkg::VALUE_WIDTH_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [VALUE_WIDTH-1:0] cfg_data,
	input  logic                   req_valid,
	output logic                   req_stall,
	input  logic                   cmd,
	input  logic [KEY_WIDTH-1:0]   range_begin,
	input  logic [KEY_WIDTH-1:0]   range_end,
	input  logic [VALUE_WIDTH-1:0] new_value,
	input  logic [KEY_WIDTH-1:0]   query_key,
	output logic                   rsp_valid,
	input  logic                   rsp_stall,
	output logic [VALUE_WIDTH-1:0] found_value,
	output logic [1:0]             status
);

	localparam int AW = $clog2(TABLE_DEPTH);
	localparam int CW = $clog2(TABLE_DEPTH + 1);
	localparam int NW = CW + 1;
	localparam logic [CW-1:0] CNT_MAX = CW'(TABLE_DEPTH);

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CHECK,
		ST_SCAN,
		ST_PLAN,
		ST_MV_RD,
		ST_MV_WR,
		ST_INS_B,
		ST_INS_E,
		ST_FIN
	} state_t;

	state_t                 state_q;
	logic [VALUE_WIDTH-1:0] default_q;
	logic [CW-1:0]          cnt_q;
	logic                   cmd_q;
	logic [KEY_WIDTH-1:0]   range_begin_q;
	logic [KEY_WIDTH-1:0]   range_end_q;
	logic [VALUE_WIDTH-1:0] new_value_q;
	logic [KEY_WIDTH-1:0]   target_q;
	logic                   pass_q;
	logic [CW-1:0]          iss_q;
	logic                   pend_q;
	logic [CW-1:0]          lo_q;
	logic [CW-1:0]          hi_q;
	logic [VALUE_WIDTH-1:0] prev_q;
	logic [VALUE_WIDTH-1:0] vend_q;
	logic                   ins_b_q;
	logic                   ins_e_q;
	logic                   mv_up_q;
	logic [CW-1:0]          off_q;
	logic [AW-1:0]          mv_src_q;
	logic [CW-1:0]          mv_left_q;
	logic [CW-1:0]          new_cnt_q;
	imrt_pkg::status_t      stat_q;
	logic                   rsp_valid_q;
	logic [VALUE_WIDTH-1:0] found_q;
	imrt_pkg::status_t      status_q;

	// memory and comparator hookup
	logic                   mem_we;
	logic [AW-1:0]          mem_waddr;
	logic [KEY_WIDTH-1:0]   mem_wkey;
	logic [VALUE_WIDTH-1:0] mem_wval;
	logic [AW-1:0]          mem_raddr;
	logic [KEY_WIDTH-1:0]   rd_key;
	logic [VALUE_WIDTH-1:0] rd_val;
	logic [KEY_WIDTH-1:0]   cmp_a;
	logic [KEY_WIDTH-1:0]   cmp_b;
	imrt_pkg::cmp_res_t     cmp_res;

	// plan terms
	logic          ins_b;
	logic          ins_e;
	logic [NW-1:0] dst_start;
	logic [CW-1:0] tail;
	logic [NW-1:0] n_new;
	logic [NW-1:0] hi_ext;
	logic [AW-1:0] mv_dst;
	logic          rsp_free;

	imrt_table_mem #(
		.TABLE_DEPTH(TABLE_DEPTH),
		.KEY_WIDTH  (KEY_WIDTH),
		.VALUE_WIDTH(VALUE_WIDTH)
	) u_mem (
		.clk    (clk),
		.wr_en  (mem_we),
		.wr_addr(mem_waddr),
		.wr_key (mem_wkey),
		.wr_val (mem_wval),
		.rd_addr(mem_raddr),
		.rd_key (rd_key),
		.rd_val (rd_val)
	);

	imrt_key_cmp #(
		.KEY_WIDTH(KEY_WIDTH)
	) u_cmp (
		.op_a(cmp_a),
		.op_b(cmp_b),
		.res (cmp_res)
	);

	assign cfg_ready   = 1'b1;
	assign req_stall   = (state_q != ST_IDLE);
	assign rsp_valid   = rsp_valid_q;
	assign found_value = found_q;
	assign status      = status_q;
	assign rsp_free    = !rsp_valid_q || !rsp_stall;

	always_comb begin
		ins_b     = (prev_q != new_value_q);
		ins_e     = (vend_q != new_value_q);
		dst_start = NW'(lo_q) + NW'(ins_b) + NW'(ins_e);
		tail      = cnt_q - hi_q;
		n_new     = dst_start + NW'(tail);
		hi_ext    = NW'(hi_q);
		mv_dst    = mv_up_q ? (mv_src_q + off_q[AW-1:0]) : (mv_src_q - off_q[AW-1:0]);
	end

	always_comb begin
		cmp_a = rd_key;
		cmp_b = target_q;
		if (state_q == ST_CHECK) begin
			cmp_a = range_begin_q;
			cmp_b = range_end_q;
		end
	end

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = '0;
		mem_wkey  = '0;
		mem_wval  = '0;
		mem_raddr = iss_q[AW-1:0];
		case (state_q)
			ST_MV_RD: begin
				mem_raddr = mv_src_q;
			end
			ST_MV_WR: begin
				mem_we    = 1'b1;
				mem_waddr = mv_dst;
				mem_wkey  = rd_key;
				mem_wval  = rd_val;
			end
			ST_INS_B: begin
				mem_we    = ins_b_q;
				mem_waddr = lo_q[AW-1:0];
				mem_wkey  = range_begin_q;
				mem_wval  = new_value_q;
			end
			ST_INS_E: begin
				mem_we    = ins_e_q;
				mem_waddr = lo_q[AW-1:0] + AW'(ins_b_q);
				mem_wkey  = range_end_q;
				mem_wval  = vend_q;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			default_q     <= '0;
			cnt_q         <= '0;
			cmd_q         <= imrt_pkg::CMD_ASSIGN;
			range_begin_q <= '0;
			range_end_q   <= '0;
			new_value_q   <= '0;
			target_q      <= '0;
			pass_q        <= 1'b0;
			iss_q         <= '0;
			pend_q        <= 1'b0;
			lo_q          <= '0;
			hi_q          <= '0;
			prev_q        <= '0;
			vend_q        <= '0;
			ins_b_q       <= 1'b0;
			ins_e_q       <= 1'b0;
			mv_up_q       <= 1'b0;
			off_q         <= '0;
			mv_src_q      <= '0;
			mv_left_q     <= '0;
			new_cnt_q     <= '0;
			stat_q        <= imrt_pkg::STAT_DONE;
			rsp_valid_q   <= 1'b0;
			found_q       <= '0;
			status_q      <= imrt_pkg::STAT_DONE;
		end else begin
			if (cfg_valid) begin
				default_q <= cfg_data;
			end
			// the final state reloads the result register itself
			if (rsp_valid_q && !rsp_stall && state_q != ST_FIN) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (req_valid) begin
						cmd_q         <= cmd;
						range_begin_q <= range_begin;
						range_end_q   <= range_end;
						new_value_q   <= new_value;
						lo_q          <= '0;
						hi_q          <= '0;
						prev_q        <= default_q;
						vend_q        <= default_q;
						iss_q         <= '0;
						pend_q        <= 1'b0;
						stat_q        <= imrt_pkg::STAT_DONE;
						if (cmd == imrt_pkg::CMD_LOOKUP) begin
							target_q <= query_key;
							pass_q   <= 1'b1;
							state_q  <= ST_SCAN;
						end else begin
							state_q <= ST_CHECK;
						end
					end
				end
				ST_CHECK: begin
					if (!cmp_res.lt) begin
						stat_q  <= imrt_pkg::STAT_EMPTY;
						state_q <= ST_FIN;
					end else begin
						target_q <= range_begin_q;
						pass_q   <= 1'b0;
						state_q  <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					// fold in the entry read last cycle
					if (pend_q) begin
						if (!pass_q) begin
							if (cmp_res.lt) begin
								lo_q   <= lo_q + CW'(1);
								prev_q <= rd_val;
							end
						end else if (cmp_res.lt || cmp_res.eq) begin
							hi_q   <= hi_q + CW'(1);
							vend_q <= rd_val;
						end
					end
					if (iss_q != cnt_q) begin
						iss_q  <= iss_q + CW'(1);
						pend_q <= 1'b1;
					end else begin
						pend_q <= 1'b0;
						if (!pend_q) begin
							if (cmd_q == imrt_pkg::CMD_LOOKUP) begin
								state_q <= ST_FIN;
							end else if (!pass_q) begin
								pass_q   <= 1'b1;
								target_q <= range_end_q;
								iss_q    <= '0;
							end else begin
								state_q <= ST_PLAN;
							end
						end
					end
				end
				ST_PLAN: begin
					ins_b_q   <= ins_b;
					ins_e_q   <= ins_e;
					new_cnt_q <= n_new[CW-1:0];
					if (n_new > NW'(TABLE_DEPTH)) begin
						stat_q  <= imrt_pkg::STAT_FULL;
						state_q <= ST_FIN;
					end else if (tail == '0 || dst_start == hi_ext) begin
						state_q <= ST_INS_B;
					end else begin
						mv_left_q <= tail;
						if (dst_start > hi_ext) begin
							// shift tail up: walk from the top down
							mv_up_q  <= 1'b1;
							off_q    <= CW'(dst_start - hi_ext);
							mv_src_q <= AW'(cnt_q - CW'(1));
						end else begin
							mv_up_q  <= 1'b0;
							off_q    <= CW'(hi_ext - dst_start);
							mv_src_q <= hi_q[AW-1:0];
						end
						state_q <= ST_MV_RD;
					end
				end
				ST_MV_RD: begin
					state_q <= ST_MV_WR;
				end
				ST_MV_WR: begin
					mv_left_q <= mv_left_q - CW'(1);
					if (mv_left_q == CW'(1)) begin
						state_q <= ST_INS_B;
					end else begin
						mv_src_q <= mv_up_q ? (mv_src_q - AW'(1)) : (mv_src_q + AW'(1));
						state_q  <= ST_MV_RD;
					end
				end
				ST_INS_B: begin
					state_q <= ST_INS_E;
				end
				ST_INS_E: begin
					cnt_q   <= new_cnt_q;
					state_q <= ST_FIN;
				end
				ST_FIN: begin
					// hold until the result register is free
					if (rsp_free) begin
						rsp_valid_q <= 1'b1;
						found_q     <= (cmd_q == imrt_pkg::CMD_LOOKUP) ? vend_q : '0;
						status_q    <= stat_q;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	`IMRT_ASSERT(a_cnt_bound, cnt_q <= CNT_MAX, "entry count exceeds table depth")
	`IMRT_ASSERT(a_cnt_commit, (cnt_q != $past(cnt_q)) |-> ($past(state_q) == ST_INS_E), "entry count changed outside commit")
	`IMRT_ASSERT(a_accept_clean, (req_valid && !req_stall) |-> !pend_q, "item accepted with a scan read in flight")

endmodule

`default_nettype wire

/* sv/imrt_key_cmp.sv */
// ----------------------------------------------------------------------------
// imrt_key_cmp
// Shared unsigned key comparator used by the range check and the scan passes of the sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module imrt_key_cmp #(
	parameter int KEY_WIDTH = imrt_pkg::KEY_WIDTH_DEF
) (
	input  logic [KEY_WIDTH-1:0] op_a,
	input  logic [KEY_WIDTH-1:0] op_b,
	output imrt_pkg::cmp_res_t   res
);

	always_comb begin
		res.lt = (op_a < op_b);
		res.eq = (op_a == op_b);
	end

endmodule

`default_nettype wire

/* sv/imrt_table_mem.sv */
// ----------------------------------------------------------------------------
// imrt_table_mem
// Breakpoint store: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
`default_nettype none

module imrt_table_mem #(
	parameter int TABLE_DEPTH = imrt_pkg::TABLE_DEPTH_DEF,
	parameter int KEY_WIDTH   = imrt_pkg::KEY_WIDTH_DEF,
	parameter int VALUE_WIDTH = imrt_pkg::VALUE_WIDTH_DEF,
	localparam int AW         = $clog2(TABLE_DEPTH)
) (
	input  logic                   clk,
	input  logic                   wr_en,
	input  logic [AW-1:0]          wr_addr,
	input  logic [KEY_WIDTH-1:0]   wr_key,
	input  logic [VALUE_WIDTH-1:0] wr_val,
	input  logic [AW-1:0]          rd_addr,
	output logic [KEY_WIDTH-1:0]   rd_key,
	output logic [VALUE_WIDTH-1:0] rd_val
);

	logic [KEY_WIDTH-1:0]   key_mem [TABLE_DEPTH];
	logic [VALUE_WIDTH-1:0] val_mem [TABLE_DEPTH];
	logic [KEY_WIDTH-1:0]   rd_key_q;
	logic [VALUE_WIDTH-1:0] rd_val_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			key_mem[wr_addr] <= wr_key;
			val_mem[wr_addr] <= wr_val;
		end
	end

	always_ff @(posedge clk) begin
		rd_key_q <= key_mem[rd_addr];
		rd_val_q <= val_mem[rd_addr];
	end

	assign rd_key = rd_key_q;
	assign rd_val = rd_val_q;

endmodule

`default_nettype wire

/* verif/range_table_checker.sv */
// ----------------------------------------------------------------------------
// range_table_checker
// Watches the configuration, request and response channels of the interval
// map range table. It keeps its own breakpoint table, predicts the result of
// every accepted item and compares each accepted result, field by field, with
// the oldest prediction still waiting.
// ----------------------------------------------------------------------------
module range_table_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [31:0] cfg_data,
	input  logic        req_valid,
	input  logic        req_stall,
	input  logic        cmd,
	input  logic [31:0] range_begin,
	input  logic [31:0] range_end,
	input  logic [31:0] new_value,
	input  logic [31:0] query_key,
	input  logic        rsp_valid,
	input  logic        rsp_stall,
	input  logic [31:0] found_value,
	input  logic [1:0]  status,
	output int          errors,
	output int          pending
);

	localparam int DEPTH = imrt_pkg::TABLE_DEPTH_DEF;

	typedef logic [imrt_pkg::KEY_WIDTH_DEF-1:0]   key_t;
	typedef logic [imrt_pkg::VALUE_WIDTH_DEF-1:0] val_t;

	typedef struct {
		val_t              found;
		imrt_pkg::status_t st;
	} table_rsp_t;

	key_t       bp_key [DEPTH];
	val_t       bp_val [DEPTH];
	int         bp_count = 0;
	val_t       dflt_value = '0;
	table_rsp_t awaited_rsp [$];
	int         err_count = 0;

	assign errors = err_count;

	function automatic val_t lookup_value(key_t k);
		val_t v;
		v = dflt_value;
		for (int i = 0; i < bp_count; i++) begin
			if (bp_key[i] <= k) begin
				v = bp_val[i];
			end else begin
				break;
			end
		end
		return v;
	endfunction

	// Rebuild the table for [b,e) := v; commit only if it fits.
	function automatic imrt_pkg::status_t apply_range(key_t b, key_t e, val_t v);
		key_t nk [DEPTH+2];
		val_t nv [DEPTH+2];
		int   n;
		int   i;
		val_t prev;
		val_t vend;
		n = 0;
		i = 0;
		prev = dflt_value;
		if (b >= e) return imrt_pkg::STAT_EMPTY;
		vend = lookup_value(e);
		while (i < bp_count && bp_key[i] < b) begin
			nk[n] = bp_key[i];
			nv[n] = bp_val[i];
			prev = bp_val[i];
			n++;
			i++;
		end
		if (prev != v) begin
			nk[n] = b;
			nv[n] = v;
			n++;
		end
		if (vend != v) begin
			nk[n] = e;
			nv[n] = vend;
			n++;
		end
		while (i < bp_count) begin
			if (bp_key[i] > e) begin
				if (n >= DEPTH + 2) return imrt_pkg::STAT_FULL;
				nk[n] = bp_key[i];
				nv[n] = bp_val[i];
				n++;
			end
			i++;
		end
		if (n > DEPTH) return imrt_pkg::STAT_FULL;
		for (int j = 0; j < n; j++) begin
			bp_key[j] = nk[j];
			bp_val[j] = nv[j];
		end
		bp_count = n;
		return imrt_pkg::STAT_DONE;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		table_rsp_t want;
		if (!arst_n) begin
			bp_count = 0;
			dflt_value = '0;
			awaited_rsp.delete();
			pending <= 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				dflt_value = cfg_data;
			end
			if (rsp_valid && !rsp_stall) begin
				if (awaited_rsp.size() == 0) begin
					$error("result with no item outstanding: found_value %h status %0d",
						found_value, status);
					err_count++;
				end else begin
					want = awaited_rsp.pop_front();
					if (found_value !== want.found) begin
						$error("found_value: expected %h, actual %h", want.found, found_value);
						err_count++;
					end
					if (status !== want.st) begin
						$error("status: expected %0d, actual %0d", want.st, status);
						err_count++;
					end
				end
			end
			if (req_valid && !req_stall) begin
				if (cmd == imrt_pkg::CMD_LOOKUP) begin
					want.found = lookup_value(query_key);
					want.st = imrt_pkg::STAT_DONE;
				end else begin
					want.found = '0;
					want.st = apply_range(range_begin, range_end, new_value);
				end
				awaited_rsp.push_back(want);
			end
			pending <= awaited_rsp.size();
		end
	end

endmodule

/* verif/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Stimulus for the interval map range table: a directed part over empty and
// reversed ranges, merges, extreme keys and table overflow, then random
// assigns and lookups over a few default values, with random idling on both
// channels and one long response hold. The checker does the comparing.
// ----------------------------------------------------------------------------
module tb;

	localparam int PHASE_ITEMS = 110;
	localparam int SETTLE      = 100;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [31:0] cfg_data = '0;
	logic        req_valid = 1'b0;
	logic        req_stall;
	logic        cmd = imrt_pkg::CMD_LOOKUP;
	logic [31:0] range_begin = '0;
	logic [31:0] range_end = '0;
	logic [31:0] new_value = '0;
	logic [31:0] query_key = '0;
	logic        rsp_valid;
	logic        rsp_stall = 1'b0;
	logic [31:0] found_value;
	logic [1:0]  status;
	int          errors;
	int          pending;
	bit          hold_rsp = 1'b0;
	bit          quiet = 1'b0;

	interval_map_range_table_core i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_data   (cfg_data),
		.req_valid  (req_valid),
		.req_stall  (req_stall),
		.cmd        (cmd),
		.range_begin(range_begin),
		.range_end  (range_end),
		.new_value  (new_value),
		.query_key  (query_key),
		.rsp_valid  (rsp_valid),
		.rsp_stall  (rsp_stall),
		.found_value(found_value),
		.status     (status)
	);

	range_table_checker i_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_data   (cfg_data),
		.req_valid  (req_valid),
		.req_stall  (req_stall),
		.cmd        (cmd),
		.range_begin(range_begin),
		.range_end  (range_end),
		.new_value  (new_value),
		.query_key  (query_key),
		.rsp_valid  (rsp_valid),
		.rsp_stall  (rsp_stall),
		.found_value(found_value),
		.status     (status),
		.errors     (errors),
		.pending    (pending)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	initial begin
		#2000000;
		$display("FAIL");
		$finish;
	end

	// Response side: random stall bursts, plus one long hold on request.
	initial begin : rsp_side
		int burst;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (hold_rsp) begin
				rsp_stall <= 1'b1;
				repeat (300) @(posedge clk);
				hold_rsp = 1'b0;
				rsp_stall <= 1'b0;
			end else if (!quiet && $urandom_range(0, 7) == 0) begin
				burst = $urandom_range(1, 15);
				rsp_stall <= 1'b1;
				repeat (burst) @(posedge clk);
				rsp_stall <= 1'b0;
			end
		end
	end

	function automatic logic [31:0] pick_key();
		int r;
		r = $urandom_range(0, 99);
		if (r < 70) return $urandom_range(0, 63);
		if (r < 80) begin
			case ($urandom_range(0, 3))
				0: return 32'h0000_0000;
				1: return 32'h0000_0001;
				2: return 32'hFFFF_FFFE;
				default: return 32'hFFFF_FFFF;
			endcase
		end
		return $urandom;
	endfunction

	function automatic logic [31:0] pick_value();
		int r;
		r = $urandom_range(0, 99);
		if (r < 75) return $urandom_range(0, 3);
		if (r < 85) return ($urandom_range(0, 1) != 0) ? 32'hFFFF_FFFF : 32'h0;
		return $urandom;
	endfunction

	// Offer one item and hold it until accepted.
	task automatic send_item(logic c, logic [31:0] b, logic [31:0] e, logic [31:0] v,
		logic [31:0] q);
		int burst;
		if (!quiet && $urandom_range(0, 5) == 0) begin
			burst = $urandom_range(1, 15);
			req_valid <= 1'b0;
			repeat (burst) @(posedge clk);
		end
		req_valid   <= 1'b1;
		cmd         <= c;
		range_begin <= b;
		range_end   <= e;
		new_value   <= v;
		query_key   <= q;
		do @(posedge clk); while (req_stall);
	endtask

	task automatic assign_range(logic [31:0] b, logic [31:0] e, logic [31:0] v);
		send_item(imrt_pkg::CMD_ASSIGN, b, e, v, $urandom);
	endtask

	task automatic lookup_key(logic [31:0] q);
		send_item(imrt_pkg::CMD_LOOKUP, $urandom, $urandom, $urandom, q);
	endtask

	task automatic wait_drained();
		req_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_default(logic [31:0] val);
		wait_drained();
		cfg_valid <= 1'b1;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	task automatic random_item();
		logic [31:0] b;
		logic [31:0] e;
		logic [31:0] t;
		if ($urandom_range(0, 99) < 45) begin
			lookup_key(pick_key());
		end else begin
			b = pick_key();
			e = pick_key();
			// mostly well-formed ranges, some left reversed
			if (b > e && $urandom_range(0, 4) != 0) begin
				t = b;
				b = e;
				e = t;
			end
			assign_range(b, e, pick_value());
		end
	endtask

	initial begin : stimulus
		logic [31:0] phase_dflt [5];
		phase_dflt[0] = 32'h0000_0001;
		phase_dflt[1] = 32'hFFFF_FFFF;
		phase_dflt[2] = $urandom;
		phase_dflt[3] = 32'h0000_0000;
		phase_dflt[4] = 32'h0000_0002;

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		write_default(32'h0);

		// empty table, empty and reversed ranges
		lookup_key(32'h0);
		lookup_key(32'hFFFF_FFFF);
		assign_range(32'd10, 32'd10, 32'd5);
		assign_range(32'd20, 32'd10, 32'd5);
		assign_range(32'd10, 32'd20, 32'd5);
		lookup_key(32'd9);
		lookup_key(32'd10);
		lookup_key(32'd19);
		lookup_key(32'd20);
		// breakpoint at range end replaced, then a merge with equal value
		assign_range(32'd15, 32'd30, 32'd7);
		assign_range(32'd20, 32'd25, 32'd7);
		// widest range and its removal
		assign_range(32'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		lookup_key(32'hFFFF_FFFF);
		assign_range(32'h0, 32'hFFFF_FFFF, 32'h0);
		// fill the table, then overflow it
		for (int k = 0; k < 9; k++) begin
			assign_range(k * 10, k * 10 + 5, k + 1);
		end
		lookup_key(32'd92);

		// first phase default equals the first entry's value
		for (int p = 0; p < 5; p++) begin
			write_default(phase_dflt[p]);
			if (p == 2) hold_rsp = 1'b1;
			if (p == 4) quiet = 1'b1;
			repeat (PHASE_ITEMS) random_item();
		end

		wait_drained();
		if (errors == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule
